// File: hw/rtl/trf_pkg.sv
// Package for the text record fingerprint unit.
// Holds the sequencer state type, the control struct and the fixed widths and moduli.
// No dependencies.
`timescale 1ns / 1ps

package trf_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned AccW  = 16;
  localparam int unsigned FpW   = 31;
  localparam int unsigned BwW   = 8;
  localparam int unsigned RwW   = 15;

  localparam logic [BwW-1:0]   ByteWeightLast   = BwW'(255 - 1);
  localparam logic [RwW-1:0]   RecordWeightLast = RwW'(32766 - 1);
  localparam logic [ByteW-1:0] GraphicLow       = 8'h21;
  localparam logic [ByteW-1:0] GraphicHigh      = 8'h7E;

  typedef enum logic [1:0] {
    StIdle,
    StByte,
    StFold
  } trf_state_e;

  typedef struct packed {
    logic in_ready;
    logic byte_step;
    logic fold_step;
  } trf_ctrl_t;

endpackage

// File: hw/rtl/trf_mul.sv
// Shared unsigned multiplier of the text record fingerprint unit.
// Serves the byte weighting step and the record folding step; depends on trf_pkg.
`timescale 1ns / 1ps

module trf_mul (
  input  logic [trf_pkg::AccW-1:0] a_i,
  input  logic [trf_pkg::RwW-1:0]  b_i,
  output logic [trf_pkg::FpW-1:0]  p_o
);
  import trf_pkg::*;

  assign p_o = FpW'(a_i) * FpW'(b_i);

endmodule

// File: hw/rtl/trf_seq.sv
// Sequencer of the text record fingerprint unit.
// Steps each input beat through the byte step and, on a record end, the fold step.
// Depends on trf_pkg.
`timescale 1ns / 1ps

module trf_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               last_i,
  input  logic               out_blocked_i,
  output trf_pkg::trf_ctrl_t ctrl_o
);
  import trf_pkg::*;

  trf_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StByte;
        end
      end
      StByte: begin
        state_d = last_i ? StFold : StIdle;
      end
      StFold: begin
        if (!out_blocked_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    unique case (state_q)
      StIdle: begin
        ctrl_o.in_ready = 1'b1;
      end
      StByte: begin
        ctrl_o.byte_step = 1'b1;
      end
      StFold: begin
        ctrl_o.fold_step = !out_blocked_i;
      end
      default: begin
        ctrl_o = '0;
      end
    endcase
  end

endmodule

// File: hw/rtl/text_record_fingerprint_unit.sv
// Top level of the text record fingerprint unit.
// Holds the hash state and the output register; uses trf_pkg, trf_seq and trf_mul.
//
// Each accepted beat carries one byte of record text. A beat is accepted in the
// idle state, then does the byte weighting multiply in the byte state; a beat that
// ends a record then does the fold multiply in the fold state, since both multiplies
// share one multiplier and the second needs the result of the first. The fold waits
// while an earlier result still sits unread in the output register. A first-of-file
// beat clears all hash state before its byte is used.
`timescale 1ns / 1ps

module text_record_fingerprint_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [trf_pkg::ByteW-1:0] byte_value_i,
  input  logic                      last_of_record_i,
  input  logic                      first_of_file_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [trf_pkg::FpW-1:0]   fingerprint_o,
  output logic [trf_pkg::AccW-1:0]  record_hash_o
);
  import trf_pkg::*;

  trf_ctrl_t        ctrl;
  logic             in_fire;
  logic             out_blocked;
  logic             graphic;
  logic [AccW-1:0]  mul_a;
  logic [RwW-1:0]   mul_b;
  logic [FpW-1:0]   prod;
  logic [FpW-1:0]   fp_next;

  logic [ByteW-1:0] byte_q, byte_d;
  logic             last_q, last_d;
  logic [AccW-1:0]  acc_q, acc_d;
  logic [FpW-1:0]   fp_q, fp_d;
  logic [BwW-1:0]   bw_q, bw_d;
  logic [RwW-1:0]   rw_q, rw_d;
  logic             out_valid_q, out_valid_d;
  logic [FpW-1:0]   out_fp_q, out_fp_d;
  logic [AccW-1:0]  out_hash_q, out_hash_d;

  assign out_blocked = out_valid_q && !out_ready_i;
  assign in_fire     = in_valid_i && ctrl.in_ready;

  trf_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .last_i       (last_q),
    .out_blocked_i(out_blocked),
    .ctrl_o       (ctrl)
  );

  assign mul_a = ctrl.fold_step ? acc_q : AccW'(byte_q);
  assign mul_b = ctrl.fold_step ? (rw_q + RwW'(1)) : RwW'(bw_q + BwW'(1));

  trf_mul u_mul (
    .a_i(mul_a),
    .b_i(mul_b),
    .p_o(prod)
  );

  assign graphic = (byte_q >= GraphicLow) && (byte_q <= GraphicHigh);
  assign fp_next = fp_q ^ prod;

  always_comb begin
    byte_d      = byte_q;
    last_d      = last_q;
    acc_d       = acc_q;
    fp_d        = fp_q;
    bw_d        = bw_q;
    rw_d        = rw_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_fp_d    = out_fp_q;
    out_hash_d  = out_hash_q;

    if (in_fire) begin
      byte_d = byte_value_i;
      last_d = last_of_record_i;
      if (first_of_file_i) begin
        acc_d = '0;
        fp_d  = '0;
        bw_d  = '0;
        rw_d  = '0;
      end
    end

    if (ctrl.byte_step && graphic) begin
      acc_d = acc_q ^ prod[AccW-1:0];
      bw_d  = (bw_q == ByteWeightLast) ? '0 : bw_q + BwW'(1);
    end

    if (ctrl.fold_step) begin
      fp_d        = fp_next;
      rw_d        = (rw_q == RecordWeightLast) ? '0 : rw_q + RwW'(1);
      acc_d       = '0;
      out_valid_d = 1'b1;
      out_fp_d    = fp_next;
      out_hash_d  = acc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q      <= 1'b0;
      acc_q       <= '0;
      fp_q        <= '0;
      bw_q        <= '0;
      rw_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      last_q      <= last_d;
      acc_q       <= acc_d;
      fp_q        <= fp_d;
      bw_q        <= bw_d;
      rw_q        <= rw_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q     <= byte_d;
    out_fp_q   <= out_fp_d;
    out_hash_q <= out_hash_d;
  end

  assign in_ready_o    = ctrl.in_ready;
  assign out_valid_o   = out_valid_q;
  assign fingerprint_o = out_fp_q;
  assign record_hash_o = out_hash_q;

endmodule
